// ===== src/bitmap_chunk_allocator_defines.svh =====
// Assertion macros shared by the bitmap chunk allocator RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef BITMAP_CHUNK_ALLOCATOR_DEFINES_SVH
`define BITMAP_CHUNK_ALLOCATOR_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define BCA_ASSERT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define BCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== src/bca_pkg.sv =====
// Shared types and constants of the bitmap chunk allocator.
// No dependencies; used by the word unit and the top level.
package bca_pkg;

  localparam int WordBits = 64;
  localparam int PosW     = 6;
  localparam int IdxW     = 10;

  typedef logic [WordBits-1:0] bca_word_t;

  typedef enum logic [1:0] {
    StatOk    = 2'd0,
    StatOom   = 2'd1,
    StatRange = 2'd2
  } bca_status_e;

  typedef enum logic {
    ReqAlloc = 1'b0,
    ReqSet   = 1'b1
  } bca_req_e;

  typedef struct packed {
    logic            set_mode;
    logic            is_first;
    logic            is_last;
    logic            set_val;
    logic [PosW-1:0] set_pos;
  } bca_wu_ctrl_t;

  typedef struct packed {
    logic            found;
    logic [PosW-1:0] pos;
  } bca_wu_res_t;

endpackage

// ===== src/bca_bitmap_ram.sv =====
// Bitmap storage: one write port and one registered read port.
// Standalone; holds one 64-bit bitmap word per entry.
module bca_bitmap_ram #(
  parameter int DEPTH = 16,
  parameter int AW    = 4,
  parameter int DW    = 64
) (
  input  logic          clk_i,
  input  logic          we_i,
  input  logic [AW-1:0] waddr_i,
  input  logic [DW-1:0] wdata_i,
  input  logic [AW-1:0] raddr_i,
  output logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/bca_word_unit.sv =====
// Shared word unit: finds the lowest free chunk of one bitmap word and
// builds the word to write back. Depends on bca_pkg.
module bca_word_unit import bca_pkg::*; #(
  parameter int FIRST_BIT = 1,
  parameter int LAST_BIT  = 63
) (
  input  bca_word_t    word_i,
  input  bca_wu_ctrl_t ctrl_i,
  output bca_wu_res_t  res_o,
  output bca_word_t    wdata_o
);

  bca_word_t       free_bits;
  bca_word_t       low_one;
  bca_word_t       set_sel;
  logic [PosW-1:0] pos_enc;

  // A free bit outside the scanned chunk range counts as used.
  always_comb begin
    for (int b = 0; b < WordBits; b++) begin
      free_bits[b] = ~word_i[b];
      if (ctrl_i.is_first && (b < FIRST_BIT)) begin
        free_bits[b] = 1'b0;
      end
      if (ctrl_i.is_last && (b > LAST_BIT)) begin
        free_bits[b] = 1'b0;
      end
    end
  end

  // Two's complement trick isolates the lowest free bit.
  assign low_one = free_bits & (~free_bits + bca_word_t'(1));

  always_comb begin
    for (int p = 0; p < PosW; p++) begin
      pos_enc[p] = 1'b0;
      for (int b = 0; b < WordBits; b++) begin
        if (((b >> p) & 1) == 1) begin
          pos_enc[p] = pos_enc[p] | low_one[b];
        end
      end
    end
  end

  assign set_sel = bca_word_t'(1) << ctrl_i.set_pos;

  always_comb begin
    if (ctrl_i.set_mode) begin
      wdata_o = ctrl_i.set_val ? (word_i | set_sel) : (word_i & ~set_sel);
    end else begin
      wdata_o = word_i | low_one;
    end
  end

  assign res_o.found = |free_bits;
  assign res_o.pos   = pos_enc;

endmodule

// ===== src/bitmap_chunk_allocator.sv =====
// Bitmap chunk allocator top level: sequencer, high-water mark and output register.
// Allocate scans one bitmap word per cycle through the shared word unit, from the
// word of FIRST_CHUNK to the first free chunk or the last usable word. An in-range
// set-status writes its word back. A new item is taken once the result is loaded.
// After reset a clearing pass writes BITMAP_WORDS words, one per cycle, before input.
// Depends on bca_pkg, bca_bitmap_ram, bca_word_unit and the defines header.
`include "bitmap_chunk_allocator_defines.svh"

module bitmap_chunk_allocator import bca_pkg::*; #(
  parameter int FIRST_CHUNK  = 1,
  parameter int LAST_CHUNK   = 1023,
  parameter int BITMAP_WORDS = 16
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  output logic            in_stall_o,
  input  logic            req_type_i,
  input  logic [IdxW-1:0] chunk_index_i,
  input  logic            mark_used_i,
  output logic            out_valid_o,
  input  logic            out_stall_i,
  output logic [IdxW-1:0] chunk_index_out_o,
  output logic [1:0]      status_o
);

  localparam int NumBits   = BITMAP_WORDS * WordBits;
  localparam int TopChunk  = (LAST_CHUNK < NumBits - 1) ? LAST_CHUNK : NumBits - 1;
  localparam bit ScanEmpty = (FIRST_CHUNK > TopChunk);
  localparam int FirstWord = FIRST_CHUNK / WordBits;
  localparam int LastWord  = TopChunk / WordBits;
  localparam int FirstBit  = FIRST_CHUNK % WordBits;
  localparam int LastBit   = TopChunk % WordBits;
  localparam int MarkMax   = (FIRST_CHUNK > TopChunk + 1) ? FIRST_CHUNK : TopChunk + 1;
  localparam int MarkW     = $clog2(MarkMax + 1);
  localparam int WordW     = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
  localparam int GotW      = WordW + PosW;
  localparam int CmpW      = ((MarkW > GotW) ? MarkW : GotW) + 1;

  typedef enum logic [2:0] {
    StClear,
    StIdle,
    StSetWr,
    StScan,
    StOut
  } state_e;

  state_e          state_q, state_d;
  logic [WordW-1:0] clr_word_q, clr_word_d;
  logic [WordW-1:0] rd_word_q, rd_word_d;
  logic [WordW-1:0] chk_word_q, chk_word_d;
  logic            issue_done_q, issue_done_d;
  logic            chk_valid_q, chk_valid_d;
  logic [MarkW-1:0] mark_q, mark_d;
  logic [PosW-1:0] set_pos_q, set_pos_d;
  logic            set_val_q, set_val_d;
  logic [IdxW-1:0] res_idx_q, res_idx_d;
  bca_status_e     res_st_q, res_st_d;
  logic            out_valid_q, out_valid_d;
  logic [IdxW-1:0] out_idx_q, out_idx_d;
  bca_status_e     out_st_q, out_st_d;

  logic             ram_we;
  logic [WordW-1:0] ram_waddr;
  bca_word_t        ram_wdata;
  logic [WordW-1:0] ram_raddr;
  bca_word_t        ram_rdata;
  bca_wu_ctrl_t     wu_ctrl;
  bca_wu_res_t      wu_res;
  bca_word_t        wu_wdata;
  logic [WordW-1:0] in_word;
  logic [GotW-1:0]  got;
  logic [CmpW-1:0]  got_next;
  logic             issue;

  bca_bitmap_ram #(
    .DEPTH (BITMAP_WORDS),
    .AW    (WordW),
    .DW    (WordBits)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  bca_word_unit #(
    .FIRST_BIT (FirstBit),
    .LAST_BIT  (LastBit)
  ) u_word_unit (
    .word_i  (ram_rdata),
    .ctrl_i  (wu_ctrl),
    .res_o   (wu_res),
    .wdata_o (wu_wdata)
  );

  assign in_word  = WordW'(chunk_index_i >> PosW);
  assign got      = {chk_word_q, wu_res.pos};
  assign got_next = CmpW'(got) + CmpW'(1);

  always_comb begin
    wu_ctrl.set_mode = (state_q == StSetWr);
    wu_ctrl.is_first = (chk_word_q == WordW'(FirstWord));
    wu_ctrl.is_last  = (chk_word_q == WordW'(LastWord));
    wu_ctrl.set_val  = set_val_q;
    wu_ctrl.set_pos  = set_pos_q;
  end

  always_comb begin
    state_d      = state_q;
    clr_word_d   = clr_word_q;
    rd_word_d    = rd_word_q;
    chk_word_d   = chk_word_q;
    issue_done_d = issue_done_q;
    chk_valid_d  = chk_valid_q;
    mark_d       = mark_q;
    set_pos_d    = set_pos_q;
    set_val_d    = set_val_q;
    res_idx_d    = res_idx_q;
    res_st_d     = res_st_q;
    out_valid_d  = out_valid_q;
    out_idx_d    = out_idx_q;
    out_st_d     = out_st_q;
    ram_we       = 1'b0;
    ram_waddr    = chk_word_q;
    ram_wdata    = wu_wdata;
    ram_raddr    = rd_word_q;
    issue        = 1'b0;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      StClear: begin
        ram_we    = 1'b1;
        ram_waddr = clr_word_q;
        ram_wdata = '0;
        if (clr_word_q == WordW'(BITMAP_WORDS - 1)) begin
          state_d = StIdle;
        end else begin
          clr_word_d = clr_word_q + WordW'(1);
        end
      end
      StIdle: begin
        ram_raddr = in_word;
        if (in_valid_i) begin
          if (req_type_i == ReqSet) begin
            res_idx_d = chunk_index_i;
            if (32'(chunk_index_i) >= NumBits) begin
              res_st_d = StatRange;
              state_d  = StOut;
            end else begin
              chk_word_d = in_word;
              set_pos_d  = chunk_index_i[PosW-1:0];
              set_val_d  = mark_used_i;
              res_st_d   = StatOk;
              state_d    = StSetWr;
            end
          end else if (ScanEmpty) begin
            res_idx_d = '0;
            res_st_d  = StatOom;
            state_d   = StOut;
          end else begin
            rd_word_d    = WordW'(FirstWord);
            issue_done_d = 1'b0;
            chk_valid_d  = 1'b0;
            state_d      = StScan;
          end
        end
      end
      StSetWr: begin
        ram_we  = 1'b1;
        state_d = StOut;
      end
      StScan: begin
        // Reads run one word ahead of the word unit.
        issue       = !issue_done_q;
        chk_valid_d = issue;
        chk_word_d  = rd_word_q;
        if (issue) begin
          if (rd_word_q == WordW'(LastWord)) begin
            issue_done_d = 1'b1;
          end else begin
            rd_word_d = rd_word_q + WordW'(1);
          end
        end
        if (chk_valid_q) begin
          if (wu_res.found) begin
            ram_we    = 1'b1;
            res_idx_d = IdxW'(got);
            res_st_d  = StatOk;
            if (got_next > CmpW'(mark_q)) begin
              mark_d = MarkW'(got_next);
            end
            state_d = StOut;
          end else if (wu_ctrl.is_last) begin
            res_idx_d = '0;
            res_st_d  = StatOom;
            // The mark runs to its limit when nothing at or above it was free.
            if (32'(mark_q) <= TopChunk) begin
              mark_d = MarkW'(TopChunk + 1);
            end
            state_d = StOut;
          end
        end
      end
      StOut: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          out_idx_d   = res_idx_q;
          out_st_d    = res_st_q;
          state_d     = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= StClear;
      clr_word_q   <= '0;
      rd_word_q    <= '0;
      chk_word_q   <= '0;
      issue_done_q <= 1'b0;
      chk_valid_q  <= 1'b0;
      mark_q       <= MarkW'(FIRST_CHUNK);
      set_pos_q    <= '0;
      set_val_q    <= 1'b0;
      res_idx_q    <= '0;
      res_st_q     <= StatOk;
      out_valid_q  <= 1'b0;
      out_idx_q    <= '0;
      out_st_q     <= StatOk;
    end else begin
      state_q      <= state_d;
      clr_word_q   <= clr_word_d;
      rd_word_q    <= rd_word_d;
      chk_word_q   <= chk_word_d;
      issue_done_q <= issue_done_d;
      chk_valid_q  <= chk_valid_d;
      mark_q       <= mark_d;
      set_pos_q    <= set_pos_d;
      set_val_q    <= set_val_d;
      res_idx_q    <= res_idx_d;
      res_st_q     <= res_st_d;
      out_valid_q  <= out_valid_d;
      out_idx_q    <= out_idx_d;
      out_st_q     <= out_st_d;
    end
  end

  assign in_stall_o        = (state_q != StIdle);
  assign out_valid_o       = out_valid_q;
  assign chunk_index_out_o = out_idx_q;
  assign status_o          = out_st_q;

  `BCA_ASSERT(mark_bound_a, 1'b1, 32'(mark_q) <= MarkMax, "high-water mark past its limit")
  `BCA_ASSERT_NEXT(mark_mono_a, 1'b1, mark_q >= $past(mark_q), "high-water mark moved back")
  `BCA_ASSERT_NEXT(grant_done_a, state_q == StScan && chk_valid_q && wu_res.found, state_q == StOut && res_st_q == StatOk, "found chunk did not end the scan")
  `BCA_ASSERT(clear_done_a, state_q == StIdle && $past(state_q) == StClear, $past(clr_word_q) == WordW'(BITMAP_WORDS - 1), "clearing pass ended early")

endmodule

// ===== tb/sv/bitmap_chunk_allocator_tb.sv =====
// Self-checking testbench for bitmap_chunk_allocator: directed, fill-to-exhaustion and churn tests.
// Tracks the bitmap and high-water mark in its own model. Needs bca_pkg and the allocator RTL.
module bitmap_chunk_allocator_tb import bca_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int          FirstChunk  = 1;
  localparam int          LastChunk   = 1023;
  localparam int          BitmapWords = 16;
  localparam int unsigned NumBits     = BitmapWords * WordBits;
  localparam int unsigned TopChunk    =
      (LastChunk < NumBits - 1) ? LastChunk : NumBits - 1;
  localparam int          CycleLimit  = 1_000_000;
  localparam int          DrainCycles = 60;

  typedef struct packed {
    logic [IdxW-1:0] chunk;
    bca_status_e     st;
  } alloc_result_t;

  logic            clk_i = 1'b0;
  logic            rst_ni = 1'b0;
  logic            in_valid_i = 1'b0;
  logic            in_stall_o;
  logic            req_type_i = 1'b0;
  logic [IdxW-1:0] chunk_index_i = '0;
  logic            mark_used_i = 1'b0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  logic [IdxW-1:0] chunk_index_out_o;
  logic [1:0]      status_o;

  // Model of the allocator state.
  logic [NumBits-1:0] used_map;
  int unsigned        mark;

  alloc_result_t pending_q[$];
  bit            calm = 1'b0;
  int            fail_cnt = 0;
  int            cycles = 0;
  int            n_ok = 0;
  int            n_oom = 0;
  int            n_set = 0;
  int            oom_predicted = 0;

  bitmap_chunk_allocator #(
    .FIRST_CHUNK (FirstChunk),
    .LAST_CHUNK  (LastChunk),
    .BITMAP_WORDS(BitmapWords)
  ) u_top (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .in_valid_i       (in_valid_i),
    .in_stall_o       (in_stall_o),
    .req_type_i       (req_type_i),
    .chunk_index_i    (chunk_index_i),
    .mark_used_i      (mark_used_i),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .chunk_index_out_o(chunk_index_out_o),
    .status_o         (status_o)
  );

  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycles, pending_q.size());
      $display("bitmap_chunk_allocator regression: fail");
      $finish;
    end
  end

  // Lowest free chunk below the mark first, then walk the mark past used chunks.
  function automatic alloc_result_t model_grab_chunk();
    alloc_result_t res;
    int unsigned   lim;
    int unsigned   i;
    res.chunk = '0;
    res.st    = StatOom;
    lim = (mark > TopChunk + 1) ? TopChunk + 1 : mark;
    for (i = FirstChunk; i < lim; i++) begin
      if (!used_map[i]) begin
        used_map[i] = 1'b1;
        res.chunk   = i[IdxW-1:0];
        res.st      = StatOk;
        return res;
      end
    end
    while (mark <= TopChunk) begin
      i = mark;
      mark++;
      if (!used_map[i]) begin
        used_map[i] = 1'b1;
        res.chunk   = i[IdxW-1:0];
        res.st      = StatOk;
        return res;
      end
    end
    return res;
  endfunction

  function automatic alloc_result_t apply_request(bca_req_e rt, logic [IdxW-1:0] idx,
                                                  logic mu);
    alloc_result_t res;
    if (rt == ReqAlloc) begin
      res = model_grab_chunk();
    end else begin
      res.chunk = idx;
      if (int'(idx) >= NumBits) begin
        res.st = StatRange;
      end else begin
        used_map[idx] = mu;
        res.st        = StatOk;
      end
    end
    return res;
  endfunction

  // Some chunk that the model holds as used, or a random one if none is.
  function automatic logic [IdxW-1:0] pick_used_chunk();
    int unsigned start;
    int unsigned j;
    start = $urandom_range(0, NumBits - 1);
    for (int unsigned k = 0; k < NumBits; k++) begin
      j = (start + k) % NumBits;
      if (used_map[j]) return j[IdxW-1:0];
    end
    return start[IdxW-1:0];
  endfunction

  // Called at a falling edge; returns at the falling edge after the transfer.
  task automatic send_req(bca_req_e rt, logic [IdxW-1:0] idx, logic mu);
    alloc_result_t res;
    while (!calm && $urandom_range(0, 99) < 13) begin
      in_valid_i <= 1'b0;
      @(negedge clk_i);
    end
    in_valid_i    <= 1'b1;
    req_type_i    <= rt;
    chunk_index_i <= idx;
    mark_used_i   <= mu;
    do @(posedge clk_i); while (in_stall_o);
    res = apply_request(rt, idx, mu);
    if (res.st == StatOom) oom_predicted++;
    pending_q.push_back(res);
    @(negedge clk_i);
  endtask

  // The index and status bit are don't-care on an allocate; keep them random.
  task automatic send_alloc();
    send_req(ReqAlloc, IdxW'($urandom), 1'($urandom));
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (pending_q.size() != 0) @(negedge clk_i);
  endtask

  always @(negedge clk_i) begin
    out_stall_i <= !calm && ($urandom_range(0, 99) < 13);
  end

  always @(posedge clk_i) begin
    alloc_result_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_q.size() == 0) begin
        $display("%0t: unexpected result chunk %0d status %0d", $time,
                 chunk_index_out_o, status_o);
        fail_cnt++;
      end else begin
        want = pending_q.pop_front();
        if (chunk_index_out_o !== want.chunk) begin
          $display("%0t: chunk index expected %0d actual %0d", $time,
                   want.chunk, chunk_index_out_o);
          fail_cnt++;
        end
        if (status_o !== want.st) begin
          $display("%0t: status expected %0d actual %0d", $time, want.st, status_o);
          fail_cnt++;
        end
        if (want.st == StatOom) n_oom++;
        else if (want.st == StatOk && status_o === StatOk) n_ok++;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && in_valid_i && !in_stall_o && req_type_i == ReqSet) n_set++;
  end

  // Reuse below the mark, skipping used chunks at the mark, writes below the
  // first chunk and far above the mark, and the index extremes.
  task automatic test_directed();
    send_alloc();
    send_alloc();
    send_alloc();
    send_req(ReqSet, 10'd2, 1'b0);
    send_alloc();
    send_req(ReqSet, 10'd0, 1'b1);
    send_alloc();
    send_req(ReqSet, 10'd5, 1'b1);
    send_alloc();
    send_req(ReqSet, 10'd1023, 1'b1);
    send_req(ReqSet, 10'd1023, 1'b0);
    send_req(ReqSet, 10'd0, 1'b0);
    send_req(ReqSet, 10'd3, 1'b0);
    send_req(ReqSet, 10'd3, 1'b1);
    send_req(ReqSet, 10'h2AA, 1'b1);
    send_req(ReqSet, 10'h155, 1'b0);
    send_req(ReqSet, 10'd8, 1'b1);
    send_req(ReqSet, 10'd9, 1'b1);
    send_alloc();
    send_alloc();
    send_req(ReqSet, 10'd1, 1'b0);
    send_alloc();
    wait_drained();
  endtask

  // Mostly allocations until the mark saturates and memory runs out.
  task automatic test_fill_until_full();
    int n;
    n = 0;
    calm = 1'b1;
    while ((oom_predicted < 30 || mark <= TopChunk) && n < 1500) begin
      if (n == 300) calm = 1'b0;
      if ($urandom_range(0, 99) < 92) send_alloc();
      else if ($urandom_range(0, 1) == 0) send_req(ReqSet, pick_used_chunk(), 1'b0);
      else send_req(ReqSet, IdxW'($urandom), 1'($urandom));
      n++;
    end
    wait_drained();
    // Full memory: free a few chunks and get them back, then run out again.
    repeat (6) send_req(ReqSet, pick_used_chunk(), 1'b0);
    repeat (8) send_alloc();
    wait_drained();
  endtask

  // Random mix of allocations, frees of held chunks and arbitrary writes.
  task automatic test_churn();
    int unsigned pick;
    for (int n = 0; n < 800; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 45) send_alloc();
      else if (pick < 80) send_req(ReqSet, pick_used_chunk(), 1'b0);
      else if (pick < 90) send_req(ReqSet, IdxW'($urandom), 1'b1);
      else send_req(ReqSet, IdxW'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    used_map = '0;
    mark     = FirstChunk;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);
    test_directed();
    test_fill_until_full();
    test_churn();
    wait_drained();
    repeat (DrainCycles) @(negedge clk_i);
    $display("Checked %0d ok replies, %0d out-of-memory replies, %0d status writes;",
             n_ok, n_oom, n_set);
    $display("high-water mark ended at %0d, %0d results left over", mark, pending_q.size());
    if (fail_cnt == 0 && pending_q.size() == 0) begin
      $display("bitmap_chunk_allocator regression: pass");
    end else begin
      $display("bitmap_chunk_allocator regression: fail");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+src
src/bca_pkg.sv
src/bca_bitmap_ram.sv
src/bca_word_unit.sv
src/bitmap_chunk_allocator.sv
tb/sv/bitmap_chunk_allocator_tb.sv
